### rtl/core/ogc_pkg.sv
// shared types and constants for the orbit gcd class counter
package ogc_pkg;

    localparam int unsigned OUT_BITS = 16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic done;
        logic coprime;
    } t_gcd_res;

endpackage

### rtl/core/ogc_gcd.sv
// iterative binary gcd unit that flags coprime operand pairs
module ogc_gcd #(
    parameter int unsigned WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    output ogc_pkg::t_gcd_res o_res
);
    import ogc_pkg::*;

    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic [WIDTH-1:0] n_a;
    logic [WIDTH-1:0] n_b;
    logic             r_run;
    logic             n_run;
    logic             r_done;
    logic             n_done;
    logic             r_cop;
    logic             n_cop;
    logic [WIDTH-1:0] w_diff_ab;
    logic [WIDTH-1:0] w_diff_ba;

    assign w_diff_ab = r_a - r_b;
    assign w_diff_ba = r_b - r_a;

    always_comb begin
        n_a    = r_a;
        n_b    = r_b;
        n_run  = r_run;
        n_done = 1'b0;
        n_cop  = r_cop;
        if (i_start) begin
            n_a   = i_a;
            n_b   = i_b;
            n_run = 1'b1;
        end else if (r_run) begin
            if ((r_a == '0) || (r_b == '0)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
                n_cop  = ((r_a | r_b) == WIDTH'(1));
            end else if (!r_a[0] && !r_b[0]) begin
                // common factor of two
                n_run  = 1'b0;
                n_done = 1'b1;
                n_cop  = 1'b0;
            end else if (!r_a[0]) begin
                n_a = r_a >> 1;
            end else if (!r_b[0]) begin
                n_b = r_b >> 1;
            end else if (r_a >= r_b) begin
                n_a = w_diff_ab >> 1;
            end else begin
                n_b = w_diff_ba >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_cop <= n_cop;
    end

    assign o_res.done    = r_done;
    assign o_res.coprime = r_cop;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_run)
        else $error("gcd started while running");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_run)
        else $error("gcd done while still running");

    a_operand_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> ((r_a != '0) || (r_b != '0)))
        else $error("gcd operands both zero while running");

endmodule

### rtl/core/orbit_gcd_class_counter_top.sv
// top level: sequencer over moduli and class counters around a shared gcd unit
// for d of 0 or 1 the sequencer goes straight to the result; else it runs the gcd unit
// once for each modulus offset m from 1 to d-1 against d
// busy stays high until the result strobe, and no new start is taken meanwhile
// the result strobe o_valid lasts one cycle and the receiver cannot stall
// reset (i_rst_n low, synchronous) returns the sequencer to idle and drops the strobe
module orbit_gcd_class_counter_top #(
    parameter int unsigned VALUE_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic [ogc_pkg::OUT_BITS-1:0]   i_increment,
    output logic                           busy,
    output logic                           o_valid,
    output logic [ogc_pkg::OUT_BITS-1:0]   o_factor_count,
    output logic [ogc_pkg::OUT_BITS-1:0]   o_cofactor_count,
    output logic [ogc_pkg::OUT_BITS-1:0]   o_coprime_count
);
    import ogc_pkg::*;

    localparam int unsigned DW = (VALUE_BITS < OUT_BITS) ? VALUE_BITS : OUT_BITS;

    t_state         r_state;
    t_state         n_state;
    logic [DW-1:0]  r_d;
    logic [DW-1:0]  n_d;
    logic [DW-1:0]  r_m;
    logic [DW-1:0]  n_m;
    logic [DW-1:0]  r_fac;
    logic [DW-1:0]  n_fac;
    logic [DW-1:0]  r_cof;
    logic [DW-1:0]  n_cof;
    logic [DW-1:0]  r_cop;
    logic [DW-1:0]  n_cop;
    logic           w_accept;
    logic           w_gcd_start;
    logic           w_last;
    logic [DW-1:0]  w_in_d;
    t_gcd_res       w_res;

    assign w_in_d   = i_increment[DW-1:0];
    assign w_accept = start && !busy;
    assign w_last   = (r_m == (r_d - DW'(1)));

    ogc_gcd #(
        .WIDTH (DW)
    ) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gcd_start),
        .i_a     (r_d),
        .i_b     (r_m),
        .o_res   (w_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (w_in_d > DW'(1)) begin
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_LOAD: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_res.done) begin
                    if (w_last) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        busy        = 1'b1;
        o_valid     = 1'b0;
        w_gcd_start = 1'b0;
        case (r_state)
            S_IDLE: busy        = 1'b0;
            S_LOAD: w_gcd_start = 1'b1;
            S_WAIT: busy        = 1'b1;
            S_DONE: o_valid     = 1'b1;
            default: busy       = 1'b1;
        endcase
    end

    // datapath
    always_comb begin
        n_d   = r_d;
        n_m   = r_m;
        n_fac = r_fac;
        n_cof = r_cof;
        n_cop = r_cop;
        if (w_accept) begin
            // offset zero has gcd d: factor, and coprime too when d is one
            n_d   = w_in_d;
            n_m   = DW'(1);
            n_fac = (w_in_d != '0) ? DW'(1) : '0;
            n_cop = (w_in_d == DW'(1)) ? DW'(1) : '0;
            n_cof = '0;
        end else if ((r_state == S_WAIT) && w_res.done) begin
            if (w_res.coprime) begin
                n_cop = r_cop + DW'(1);
            end else begin
                n_cof = r_cof + DW'(1);
            end
            n_m = r_m + DW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_d   <= n_d;
        r_m   <= n_m;
        r_fac <= n_fac;
        r_cof <= n_cof;
        r_cop <= n_cop;
    end

    assign o_factor_count   = OUT_BITS'(r_fac);
    assign o_cofactor_count = OUT_BITS'(r_cof);
    assign o_coprime_count  = OUT_BITS'(r_cop);

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe while not busy");

    a_end_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> $past(o_valid))
        else $error("busy dropped without a result");

    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_d > DW'(1))) |->
        (({1'b0, r_fac} + {1'b0, r_cof} + {1'b0, r_cop}) == {1'b0, r_d}))
        else $error("class counts do not cover all moduli");

    a_gcd_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.done |-> (r_state == S_WAIT))
        else $error("gcd result outside wait state");

endmodule
